@@ rtl/asxu_pkg.sv @@
`timescale 1ns / 1ps
package asxu_pkg;

  typedef enum logic [3:0] {
    CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_MOV = 4'd2, CMD_AND = 4'd3,
    CMD_ORR = 4'd4, CMD_EOR = 4'd5, CMD_LSL = 4'd6, CMD_LSR = 4'd7,
    CMD_MVN = 4'd8, CMD_LDR = 4'd9, CMD_STR = 4'd10, CMD_CMP = 4'd11,
    CMD_BEQ = 4'd12, CMD_NOP = 4'd13, CMD_INVALID = 4'd14, CMD_LABEL = 4'd15
  } cmd_t;

  localparam logic [2:0] COND_AL = 3'd0;
  localparam logic [2:0] COND_EQ = 3'd1;
  localparam logic [2:0] COND_NE = 3'd2;
  localparam logic [2:0] COND_GT = 3'd3;
  localparam logic [2:0] COND_GE = 3'd4;
  localparam logic [2:0] COND_LT = 3'd5;
  localparam logic [2:0] COND_LE = 3'd6;
  localparam logic [2:0] COND_NV = 3'd7;

  // register index, taken from paddr[2]
  localparam logic REG_DATA_BASE = 1'b0;

  // tdata: cmd, cond_code, set_flags, dest_reg, first_reg, second_is_imm,
  // second_reg, imm_value, branch_target
  typedef struct packed {
    logic [8:0]  branch_target;
    logic [31:0] imm_value;
    logic [3:0]  second_reg;
    logic        second_is_imm;
    logic [3:0]  first_reg;
    logic [3:0]  dest_reg;
    logic        set_flags;
    logic [2:0]  cond_code;
    logic [3:0]  cmd;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  mem_slot;
    logic        mem_written;
    logic [31:0] reg_value;
    logic [3:0]  reg_index;
    logic        reg_written;
    logic [3:0]  flags_nzcv;
    logic [8:0]  next_index;
    logic        branch_taken;
    logic        executed;
  } out_word_t;

endpackage

@@ rtl/arm_subset_execute_unit.sv @@
`timescale 1ns / 1ps
// channel | direction | handshake              | payload
// in_     | slave     | in_tvalid / in_tready  | decoded instruction word
// out_    | master    | out_tvalid / out_tready| execution report word
// cfg_    | apb       | psel, penable, pready  | data base address at address 0
// one instruction per cycle unless stalled; result appears the cycle after accept
// registers and flags are flip-flops read combinationally, data words sit in a
// memory written in the accept cycle and read with valid bits (reset clears them)
// in_tready is low only while the output register holds a word not yet taken
// reset is synchronous, active low; it clears all state but the data words and out_r
module arm_subset_execute_unit #(
  parameter int NUM_REGS      = 12,
  parameter int MEM_WORDS     = 5,
  parameter int PROGRAM_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cmd, cond_code, set_flags, dest_reg, first_reg, second_is_imm, second_reg,
  // imm_value, branch_target
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // executed, branch_taken, next_index, flags_nzcv, reg_written, reg_index,
  // reg_value, mem_written, mem_slot
  output logic [55:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import asxu_pkg::*;

  localparam int SW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int PW = $clog2(PROGRAM_DEPTH + 1);

  logic [31:0]         regs_r [NUM_REGS];
  logic [31:0]         dmem_r [MEM_WORDS];
  logic [MEM_WORDS-1:0] dvalid_r;
  logic [3:0]          flags_r;
  logic [PW-1:0]       pc_r;
  logic [31:0]         data_base_r;
  logic                out_valid_r;
  out_word_t           out_r;

  in_word_t  iw;
  out_word_t ow;
  logic      accept, cond, exec;
  logic [31:0] op_a, op_b, alu_res, rd_val, off;
  logic        alu_wr, addr_ok, rd_ok;
  logic [3:0]  alu_flags, flags_nxt;
  logic [SW-1:0] slot;
  logic [PW-1:0] pc_nxt;
  logic [31:0] ld_val;
  logic        do_st, do_rw;
  logic [31:0] res;
  logic        nv;

  assign iw        = in_word_t'(in_tdata[61:0]);
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_DATA_BASE) ? data_base_r : 32'd0;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  asxu_alu u_alu (
    .cmd(iw.cmd), .set_flags(iw.set_flags), .op_a(op_a), .op_b(op_b),
    .flags_in(flags_r), .result(alu_res), .writes(alu_wr), .flags_out(alu_flags)
  );

  always_comb begin
    op_a   = (32'(iw.first_reg) < NUM_REGS) ? regs_r[iw.first_reg] : 32'd0;
    op_b   = iw.second_is_imm ? iw.imm_value :
             ((32'(iw.second_reg) < NUM_REGS) ? regs_r[iw.second_reg] : 32'd0);
    rd_ok  = 32'(iw.dest_reg) < NUM_REGS;
    rd_val = rd_ok ? regs_r[iw.dest_reg] : 32'd0;
    nv     = flags_r[3] == flags_r[0];
    unique case (iw.cond_code)
      COND_AL: cond = 1'b1;
      COND_EQ: cond = flags_r[2];
      COND_NE: cond = !flags_r[2];
      COND_GT: cond = !flags_r[2] && nv;
      COND_GE: cond = nv;
      COND_LT: cond = !nv;
      COND_LE: cond = flags_r[2] || !nv;
      default: cond = 1'b0;
    endcase
    exec    = cond && (iw.cmd != CMD_LABEL);
    off     = op_a - data_base_r;
    addr_ok = (op_a >= data_base_r) && (off[1:0] == 2'b00) &&
              ({2'b00, off[31:2]} < 32'(MEM_WORDS));
    slot    = off[SW+1:2];
    ld_val  = dvalid_r[slot] ? dmem_r[slot] : 32'd0;
    pc_nxt  = (32'(pc_r) >= PROGRAM_DEPTH) ? PW'(PROGRAM_DEPTH) : pc_r + PW'(1);
    flags_nxt = flags_r;
    res     = 32'd0;
    do_rw   = 1'b0;
    do_st   = 1'b0;
    ow      = '0;
    if (exec) begin
      case (iw.cmd)
        CMD_LDR: begin
          res   = ld_val;
          do_rw = addr_ok && rd_ok;
        end
        CMD_STR: do_st = addr_ok && rd_ok;
        CMD_BEQ: begin
          if (flags_r[2] && !iw.branch_target[8]) begin
            ow.branch_taken = 1'b1;
            pc_nxt = (32'(iw.branch_target) > PROGRAM_DEPTH) ? PW'(PROGRAM_DEPTH)
                                                            : PW'(iw.branch_target);
          end
        end
        default: begin
          res       = alu_res;
          do_rw     = alu_wr && rd_ok;
          flags_nxt = alu_flags;
        end
      endcase
    end
    ow.executed    = exec;
    ow.next_index  = 9'(pc_nxt);
    ow.flags_nzcv  = flags_nxt;
    ow.reg_written = do_rw;
    ow.reg_index   = do_rw ? iw.dest_reg : 4'd0;
    ow.reg_value   = do_rw ? res : 32'd0;
    ow.mem_written = do_st;
    ow.mem_slot    = do_st ? 3'(slot) : 3'd0;
  end

  always_ff @(posedge clk) begin
    if (accept && do_st) dmem_r[slot] <= rd_val;
    if (accept) out_r <= ow;
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) regs_r[i] <= 32'd0;
      dvalid_r    <= '0;
      flags_r     <= 4'd0;
      pc_r        <= '0;
      data_base_r <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_DATA_BASE)
        data_base_r <= cfg_pwdata;
      if (accept) begin
        if (do_rw) regs_r[iw.dest_reg] <= res;
        flags_r <= flags_nxt;
        pc_r    <= pc_nxt;
        if (do_st) dvalid_r[slot] <= 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_r))
    else $error("output word changed under stall");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !accept)
    else $error("accepted while output blocked");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_r.flags_nzcv == flags_r)
    else $error("reported flags differ from state");
  a_pc: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> 32'(out_r.next_index) == 32'(pc_r))
    else $error("reported index differs from state");

endmodule

@@ rtl/asxu_alu.sv @@
`timescale 1ns / 1ps
module asxu_alu (
  input  logic [3:0]  cmd,
  input  logic        set_flags,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  input  logic [3:0]  flags_in,
  output logic [31:0] result,
  output logic        writes,
  output logic [3:0]  flags_out
);
  import asxu_pkg::*;

  logic [32:0] sum;
  logic [32:0] diff;
  logic [4:0]  sh;
  logic [63:0] lsl_w;
  logic [63:0] lsr_w;
  logic        n, z, c, v;
  logic        upd_nz, upd_cv;

  always_comb begin
    sum    = {1'b0, op_a} + {1'b0, op_b};
    diff   = {1'b0, op_a} - {1'b0, op_b};
    sh     = op_b[4:0];
    lsl_w  = {32'd0, op_a} << sh;
    lsr_w  = {op_a, 32'd0} >> sh;
    result = 32'd0;
    writes = 1'b1;
    c      = flags_in[1];
    v      = flags_in[0];
    upd_nz = set_flags;
    upd_cv = 1'b0;
    case (cmd)
      CMD_ADD: begin
        result = sum[31:0];
        c = sum[32];
        v = (op_a[31] == op_b[31]) && (op_a[31] != sum[31]);
        upd_cv = set_flags;
      end
      CMD_SUB, CMD_CMP: begin
        result = diff[31:0];
        c = ~diff[32];
        v = (op_a[31] != op_b[31]) && (op_a[31] != diff[31]);
        upd_cv = set_flags || (cmd == CMD_CMP);
        if (cmd == CMD_CMP) begin
          writes = 1'b0;
          upd_nz = 1'b1;
        end
      end
      CMD_MOV: result = op_b;
      CMD_AND: result = op_a & op_b;
      CMD_ORR: result = op_a | op_b;
      CMD_EOR: result = op_a ^ op_b;
      CMD_MVN: result = ~op_b;
      CMD_LSL: begin
        result = lsl_w[31:0];
        c = lsl_w[32];
        upd_cv = set_flags && (sh != 5'd0);
      end
      CMD_LSR: begin
        result = lsr_w[63:32];
        c = lsr_w[31];
        upd_cv = set_flags && (sh != 5'd0);
      end
      default: begin
        writes = 1'b0;
        upd_nz = 1'b0;
      end
    endcase
    n = upd_nz ? result[31] : flags_in[3];
    z = upd_nz ? (result == 32'd0) : flags_in[2];
    flags_out = {n, z, upd_cv ? c : flags_in[1], upd_cv ? v : flags_in[0]};
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import asxu_pkg::*;

  localparam int NREG = 12;
  localparam int NWORD = 5;
  localparam int DEPTH = 256;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  arm_subset_execute_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow machine state
  logic [31:0] gpr [NREG];
  logic [31:0] dmem [NWORD];
  logic [3:0]  nzcv;
  logic [8:0]  pc;
  logic [31:0] base_addr;

  in_word_t  instr_q [$];
  out_word_t report_q [$];
  int mismatches = 0;
  int words_seen = 0;
  int taken_seen = 0;
  int cycles = 0;

  function automatic logic [31:0] rd_gpr(logic [3:0] r);
    return (r < NREG) ? gpr[r] : 32'd0;
  endfunction

  function automatic logic cond_holds(logic [2:0] c);
    logic z, nv;
    z = nzcv[2];
    nv = (nzcv[3] == nzcv[0]);
    case (c)
      COND_AL: return 1'b1;
      COND_EQ: return z;
      COND_NE: return !z;
      COND_GT: return !z && nv;
      COND_GE: return nv;
      COND_LT: return !nv;
      COND_LE: return z || !nv;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void set_nz(logic [31:0] r);
    nzcv[3] = r[31];
    nzcv[2] = (r == 32'd0);
  endfunction

  function automatic void set_sub(logic [31:0] a, logic [31:0] b, logic [31:0] r);
    set_nz(r);
    nzcv[1] = (a >= b);
    nzcv[0] = (a[31] ^ b[31]) & (a[31] ^ r[31]);
  endfunction

  function automatic logic find_slot(logic [31:0] addr, output logic [2:0] slot);
    logic [31:0] off;
    slot = '0;
    if (addr < base_addr) return 1'b0;
    off = addr - base_addr;
    if (off[1:0] != 2'b00) return 1'b0;
    off = off >> 2;
    if (off >= NWORD) return 1'b0;
    slot = off[2:0];
    return 1'b1;
  endfunction

  function automatic out_word_t execute_instr(in_word_t w);
    out_word_t o;
    logic [31:0] a, b, res;
    logic [2:0] slot;
    logic [4:0] sh;
    logic wr;
    logic [8:0] nxt;
    o = '0;
    wr = 1'b0;
    res = '0;
    a = rd_gpr(w.first_reg);
    b = w.second_is_imm ? w.imm_value : rd_gpr(w.second_reg);
    nxt = (pc >= DEPTH) ? 9'(DEPTH) : pc + 9'd1;
    if (cmd_t'(w.cmd) != CMD_LABEL && cond_holds(w.cond_code)) begin
      o.executed = 1'b1;
      case (cmd_t'(w.cmd))
        CMD_ADD: begin
          res = a + b; wr = 1'b1;
          if (w.set_flags) begin
            set_nz(res);
            nzcv[1] = (res < a);
            nzcv[0] = (a[31] ^ ~b[31]) & (a[31] ^ res[31]);
          end
        end
        CMD_SUB: begin
          res = a - b; wr = 1'b1;
          if (w.set_flags) set_sub(a, b, res);
        end
        CMD_MOV: begin res = b; wr = 1'b1; if (w.set_flags) set_nz(res); end
        CMD_AND: begin res = a & b; wr = 1'b1; if (w.set_flags) set_nz(res); end
        CMD_ORR: begin res = a | b; wr = 1'b1; if (w.set_flags) set_nz(res); end
        CMD_EOR: begin res = a ^ b; wr = 1'b1; if (w.set_flags) set_nz(res); end
        CMD_MVN: begin res = ~b; wr = 1'b1; if (w.set_flags) set_nz(res); end
        CMD_LSL: begin
          sh = b[4:0]; res = a << sh; wr = 1'b1;
          if (w.set_flags) begin
            if (sh != 0) nzcv[1] = a[6'd32 - sh];
            set_nz(res);
          end
        end
        CMD_LSR: begin
          sh = b[4:0]; res = a >> sh; wr = 1'b1;
          if (w.set_flags) begin
            if (sh != 0) nzcv[1] = a[sh - 5'd1];
            set_nz(res);
          end
        end
        CMD_LDR: begin
          if (find_slot(a, slot)) begin res = dmem[slot]; wr = 1'b1; end
        end
        CMD_STR: begin
          if (find_slot(a, slot) && w.dest_reg < NREG) begin
            dmem[slot] = gpr[w.dest_reg];
            o.mem_written = 1'b1;
            o.mem_slot = slot;
          end
        end
        CMD_CMP: set_sub(a, b, a - b);
        CMD_BEQ: begin
          if (nzcv[2] && !w.branch_target[8]) begin
            o.branch_taken = 1'b1;
            nxt = w.branch_target;
          end
        end
        default: ;
      endcase
      if (wr && w.dest_reg < NREG) begin
        gpr[w.dest_reg] = res;
        o.reg_written = 1'b1;
        o.reg_index = w.dest_reg;
        o.reg_value = res;
      end
    end
    pc = nxt;
    o.next_index = nxt;
    o.flags_nzcv = nzcv;
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        report_q.push_back(execute_instr(in_word_t'(in_tdata[61:0])));
        void'(instr_q.pop_front());
      end
      if (!(in_tvalid && !in_tready)) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if ((instr_q.size() > 1 || (instr_q.size() == 1 && !(in_tvalid && in_tready)))
                     && !cfg_psel) begin
          in_tvalid <= 1'b1;
          in_tdata <= {2'd0, instr_q[0]};
          in_gap <= pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int out_hold = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        out_word_t got, want;
        got = out_word_t'(out_tdata);
        words_seen <= words_seen + 1;
        if (got.branch_taken) taken_seen <= taken_seen + 1;
        if (report_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected word %h", got);
        end else begin
          want = report_q.pop_front();
          if (got !== want) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: exp ex%0b br%0b nx%0d f%h rw%0b r%0d v%h mw%0b s%0d / got ex%0b br%0b nx%0d f%h rw%0b r%0d v%h mw%0b s%0d",
                want.executed, want.branch_taken, want.next_index, want.flags_nzcv,
                want.reg_written, want.reg_index, want.reg_value, want.mem_written,
                want.mem_slot, got.executed, got.branch_taken, got.next_index,
                got.flags_nzcv, got.reg_written, got.reg_index, got.reg_value,
                got.mem_written, got.mem_slot);
          end
        end
      end
      if (out_hold > 0) begin
        out_hold <= out_hold - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_hold <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic in_word_t make_instr(cmd_t c, logic [2:0] cc, logic sf, logic [3:0] rd,
                                          logic [3:0] rn, logic si, logic [3:0] rm,
                                          logic [31:0] imm, logic [8:0] tgt);
    in_word_t w;
    w.cmd = c; w.cond_code = cc; w.set_flags = sf; w.dest_reg = rd;
    w.first_reg = rn; w.second_is_imm = si; w.second_reg = rm;
    w.imm_value = imm; w.branch_target = tgt;
    return w;
  endfunction

  function automatic logic [3:0] any_reg();
    return ($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15)) : 4'($urandom_range(0, 11));
  endfunction

  function automatic logic [31:0] any_value();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  // mostly word-aligned addresses in and around the data window
  function automatic logic [31:0] mem_addr();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return base_addr + 32'($urandom_range(0, 6) * 4) - 32'($urandom_range(0, 1) * 4)
           + 32'(($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
  endfunction

  function automatic in_word_t random_instr();
    in_word_t w;
    w = 62'({$urandom, $urandom});
    w.cmd = cmd_t'($urandom_range(0, 15));
    w.cond_code = ($urandom_range(0, 2) == 0) ? 3'($urandom_range(0, 7)) : COND_AL;
    w.dest_reg = any_reg();
    w.first_reg = any_reg();
    w.second_reg = any_reg();
    w.imm_value = any_value();
    if (w.cmd == CMD_LSL || w.cmd == CMD_LSR)
      w.imm_value = ($urandom_range(0, 1)) ? 32'($urandom_range(0, 31)) : $urandom;
    w.branch_target = ($urandom_range(0, 5) == 0) ? 9'($urandom) : 9'($urandom_range(0, 300));
    return w;
  endfunction

  task automatic wait_idle();
    while (instr_q.size() != 0 || report_q.size() != 0 || in_tvalid) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_base(logic [31:0] v);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {REG_DATA_BASE, 2'b00}; cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    base_addr = v;
    @(posedge clk);
  endtask

  initial begin
    logic [31:0] bases [4];
    in_word_t w;
    for (int i = 0; i < NREG; i++) gpr[i] = '0;
    for (int i = 0; i < NWORD; i++) dmem[i] = '0;
    nzcv = '0; pc = '0; base_addr = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every op, flag corners, memory edges, branches
    instr_q.push_back(make_instr(CMD_MOV, COND_AL, 1, 0, 12, 1, 0, 32'hFFFF_FFFF, 0));
    instr_q.push_back(make_instr(CMD_ADD, COND_AL, 1, 1, 0, 1, 0, 32'd1, 0));
    instr_q.push_back(make_instr(CMD_BEQ, COND_AL, 0, 12, 12, 0, 12, 0, 9'd255));
    instr_q.push_back(make_instr(CMD_BEQ, COND_AL, 0, 12, 12, 0, 12, 0, 9'h1FF));
    instr_q.push_back(make_instr(CMD_MOV, COND_AL, 1, 2, 12, 1, 0, 32'h7FFF_FFFF, 0));
    instr_q.push_back(make_instr(CMD_ADD, COND_AL, 1, 3, 2, 1, 0, 32'd1, 0));
    instr_q.push_back(make_instr(CMD_SUB, COND_AL, 1, 4, 3, 1, 0, 32'd1, 0));
    instr_q.push_back(make_instr(CMD_CMP, COND_AL, 0, 0, 1, 0, 1, 0, 0));
    instr_q.push_back(make_instr(CMD_BEQ, COND_EQ, 0, 12, 12, 0, 12, 0, 9'd10));
    instr_q.push_back(make_instr(CMD_LSL, COND_AL, 1, 5, 0, 1, 0, 32'd31, 0));
    instr_q.push_back(make_instr(CMD_LSR, COND_AL, 1, 6, 0, 1, 0, 32'd32, 0));
    instr_q.push_back(make_instr(CMD_LSR, COND_AL, 1, 6, 0, 1, 0, 32'd1, 0));
    instr_q.push_back(make_instr(CMD_AND, COND_GT, 1, 7, 0, 0, 2, 0, 0));
    instr_q.push_back(make_instr(CMD_ORR, COND_LT, 1, 8, 3, 0, 2, 0, 0));
    instr_q.push_back(make_instr(CMD_EOR, COND_GE, 1, 9, 0, 0, 0, 0, 0));
    instr_q.push_back(make_instr(CMD_MVN, COND_LE, 1, 15, 12, 1, 0, 0, 0));
    instr_q.push_back(make_instr(CMD_MOV, COND_NE, 0, 10, 12, 1, 0, 32'd16, 0));
    instr_q.push_back(make_instr(CMD_STR, COND_AL, 0, 0, 10, 0, 0, 0, 0));
    instr_q.push_back(make_instr(CMD_STR, COND_AL, 0, 0, 12, 0, 0, 0, 0));
    instr_q.push_back(make_instr(CMD_LDR, COND_AL, 0, 11, 10, 0, 0, 0, 0));
    instr_q.push_back(make_instr(CMD_LDR, COND_AL, 0, 11, 0, 0, 0, 0, 0));
    instr_q.push_back(make_instr(CMD_NOP, COND_NV, 1, 0, 0, 1, 0, 32'hFFFF_FFFF, 0));
    instr_q.push_back(make_instr(CMD_INVALID, COND_AL, 1, 0, 0, 0, 0, 0, 0));
    instr_q.push_back(make_instr(CMD_LABEL, COND_AL, 1, 0, 0, 0, 0, 0, 0));
    wait_idle();

    bases[0] = 32'hFFFF_FFF0;
    bases[1] = 32'h0000_1000;
    bases[2] = 32'hFFFF_FFFF;
    bases[3] = 32'd0;
    for (int ph = 0; ph < 4; ph++) begin
      write_base(bases[ph]);
      for (int n = 0; n < 340; n++) begin
        w = random_instr();
        // point loads and stores at the data window, and turn some other ops into stores
        if (w.cmd == CMD_LDR || w.cmd == CMD_STR || $urandom_range(0, 7) == 0) begin
          instr_q.push_back(make_instr(CMD_MOV, COND_AL, 0, 4'(w.first_reg % 12), 12, 1, 0,
                                       mem_addr(), 0));
          w.first_reg = 4'(w.first_reg % 12);
          if (w.cmd != CMD_LDR) w.cmd = CMD_STR;
        end
        // compare then branch, so BEQ gets taken often
        if ($urandom_range(0, 9) == 0) begin
          instr_q.push_back(make_instr(CMD_CMP, COND_AL, 0, 0, w.first_reg, 0,
                                       w.first_reg, 0, 0));
          w.cmd = CMD_BEQ;
        end
        instr_q.push_back(w);
        while (instr_q.size() > 16) @(posedge clk);
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    $display("covered %0d instruction words, %0d taken branches, four memory bases",
             words_seen, taken_seen);
    if (mismatches == 0 && report_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
